// ----- hw/rtl/rorq_pkg.sv -----
// ----------------------------------------------------------------------------
// Run queue package
// Shared types, field widths and codes for the runtime-ordered run queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rorq_pkg;

    localparam int ID_W    = 8;
    localparam int RT_W    = 63;
    localparam int PRI_W   = 3;
    localparam int SLICE_W = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 6;

    // Slice reload base and the priority that earns a long slice
    localparam logic [SLICE_W-1:0] SLICE_BASE   = 4'd4;
    localparam logic [PRI_W-1:0]   LONG_PRI_MIN = 3'd2;

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SCHED  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_IDLE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_IDLE_ID  = 1'b0;
    localparam logic CFG_IDLE_PRI = 1'b1;

    // One queue entry
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [RT_W-1:0]  rt;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage : rorq_pkg

`default_nettype wire

// ----- hw/rtl/rorq_cell.sv -----
// ----------------------------------------------------------------------------
// Run queue cell
// Holds one entry of the sorted chain; shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module rorq_cell
    import rorq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire logic       left_lt,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output logic            lt
);

    entry_t entry_reg;
    entry_t entry_next;

    // Flag an occupied entry that sorts strictly before the new one
    assign lt    = occupied && (entry_reg.rt < ctrl.new_entry.rt);
    assign entry = entry_reg;

    // Keep, take the new entry at the boundary, or shift
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (!lt)
            begin
                if (left_lt)
                begin
                    entry_next = ctrl.new_entry;
                end
                else
                begin
                    entry_next = left_entry;
                end
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule : rorq_cell

`default_nettype wire

// ----- hw/rtl/runtime_ordered_run_queue.sv -----
// ----------------------------------------------------------------------------
// Runtime-ordered run queue
// Per-CPU run queue sorted by virtual runtime, with a schedule decision.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with the operand ports while busy is low; the
//   beat is taken at that edge and busy rises. func selects insert or schedule.
//   Result channel: done pulses for one cycle with status, run_task_id,
//   switched, slice_next and task_count valid in that same cycle.
//   Sequence: an insert steps through the insert and done states, a schedule
//   through pop, decide, insert and done; busy stays high through the done
//   cycle, so the next command is taken only once the queue is back in idle.
//   The control sequence over the cell chain pops the head, compares
//   runtimes, inserts into the chain (every cell compares against the new
//   entry in parallel) and forms the result.
//   Configuration: cfg_valid/cfg_ready beats write idle_task_id (index 0) or
//   idle_priority (index 1); cfg_ready is always high. Write only while idle.
//   Reset: the queue empties and both registers return to zero. Entry storage
//   is not cleared; only occupied cells are ever read.
//   The receiver cannot stall: each result is presented for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module runtime_ordered_run_queue
    import rorq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               func,
    input  wire logic [ID_W-1:0]    task_id,
    input  wire logic [RT_W-1:0]    task_runtime,
    input  wire logic [PRI_W-1:0]   task_priority,
    input  wire logic               current_running,
    input  wire logic [RT_W-1:0]    idle_runtime,
    input  wire logic [SLICE_W-1:0] slice_now,
    // result channel
    output logic                    done,
    output logic [STAT_W-1:0]       status,
    output logic [ID_W-1:0]         run_task_id,
    output logic                    switched,
    output logic [SLICE_W-1:0]      slice_next,
    output logic [COUNT_W-1:0]      task_count,
    // configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [ID_W-1:0]    cfg_data
);

    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W = ($clog2(QUEUE_DEPTH + 2) < 3) ? 3 : $clog2(QUEUE_DEPTH + 2);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_POP    = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_INSERT = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t               state_reg,   state_next;
    logic [LEN_W-1:0]     len_reg,     len_next;
    logic [ID_W-1:0]      idle_id_reg;
    logic [PRI_W-1:0]     idle_pri_reg;

    // Operand hold registers
    logic                 func_reg;
    entry_t               cur_reg;
    logic                 crun_reg;
    logic [RT_W-1:0]      idle_rt_reg;
    logic [SLICE_W-1:0]   snow_reg;

    // Working registers
    entry_t               pick_reg,    pick_next;
    entry_t               cand_reg,    cand_next;
    logic                 enq_reg,     enq_next;
    logic                 sw_reg,      sw_next;
    logic [ID_W-1:0]      run_id_reg,  run_id_next;
    logic [STAT_W-1:0]    stat_reg,    stat_next;

    cell_ctrl_t           ctrl;
    entry_t               cell_entry [QUEUE_DEPTH];
    logic                 cell_lt    [QUEUE_DEPTH];
    logic                 full;
    logic                 accept;
    logic [CNT_W-1:0]     run_cnt;
    logic [SLICE_W-1:0]   slice_q;
    logic [SLICE_W-1:0]   slice_val;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign full      = (len_reg == LEN_W'(QUEUE_DEPTH));

    // Build the cell chain
    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            logic   left_lt_w;
            entry_t left_w;
            entry_t right_w;

            if (k == 0)
            begin : g_head
                assign left_lt_w = 1'b1;
                assign left_w    = ctrl.new_entry;
            end
            else
            begin : g_body
                assign left_lt_w = cell_lt[k-1];
                assign left_w    = cell_entry[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_w = cell_entry[k];
            end
            else
            begin : g_mid
                assign right_w = cell_entry[k+1];
            end

            rorq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (LEN_W'(k) < len_reg),
                .left_lt     (left_lt_w),
                .left_entry  (left_w),
                .right_entry (right_w),
                .entry       (cell_entry[k]),
                .lt          (cell_lt[k])
            );
        end
    endgenerate

    // Sequence the operation and drive the chain
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        pick_next      = pick_reg;
        cand_next      = cand_reg;
        enq_next       = enq_reg;
        sw_next        = sw_reg;
        run_id_next    = run_id_reg;
        stat_next      = stat_reg;
        ctrl.ins       = 1'b0;
        ctrl.pop       = 1'b0;
        ctrl.new_entry = cand_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cand_next.id  = task_id;
                    cand_next.rt  = task_runtime;
                    cand_next.pri = task_priority;
                    enq_next      = 1'b1;
                    sw_next       = 1'b0;
                    run_id_next   = '0;
                    stat_next     = STAT_DONE;
                    if (func == FUNC_SCHED)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_POP:
            begin
                // take the head, or the idle task on an empty queue
                if (len_reg != '0)
                begin
                    pick_next = cell_entry[0];
                    ctrl.pop  = 1'b1;
                    len_next  = len_reg - LEN_W'(1);
                end
                else
                begin
                    pick_next.id  = idle_id_reg;
                    pick_next.rt  = idle_rt_reg;
                    pick_next.pri = idle_pri_reg;
                end
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (cur_reg.rt >= pick_reg.rt)
                begin
                    sw_next     = 1'b1;
                    run_id_next = pick_reg.id;
                    cand_next   = cur_reg;
                    enq_next    = crun_reg;
                end
                else
                begin
                    sw_next     = 1'b0;
                    run_id_next = cur_reg.id;
                    cand_next   = pick_reg;
                    enq_next    = 1'b1;
                end
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                // drop idle-task inserts and inserts into a full queue
                if (enq_reg)
                begin
                    if (cand_reg.id == idle_id_reg)
                    begin
                        stat_next = STAT_IDLE;
                    end
                    else if (full)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        ctrl.ins = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Reload slice: base over task count, tripled for long-slice priorities
    assign run_cnt = CNT_W'(len_reg) + CNT_W'(1);

    always_comb
    begin
        if (run_cnt > CNT_W'(SLICE_BASE))
        begin
            slice_q = '0;
        end
        else if (run_cnt == CNT_W'(1))
        begin
            slice_q = SLICE_BASE;
        end
        else if (run_cnt == CNT_W'(2))
        begin
            slice_q = SLICE_BASE >> 1;
        end
        else
        begin
            slice_q = SLICE_BASE >> 2;
        end
        if (pick_reg.pri >= LONG_PRI_MIN)
        begin
            slice_q = slice_q + (slice_q << 1);
        end
        if (snow_reg != '0)
        begin
            slice_val = snow_reg;
        end
        else
        begin
            slice_val = slice_q;
        end
    end

    // Present the result beat
    assign done        = (state_reg == ST_DONE);
    assign status      = (func_reg == FUNC_SCHED) ? STAT_DONE : stat_reg;
    assign run_task_id = run_id_reg;
    assign switched    = sw_reg;
    assign slice_next  = (func_reg == FUNC_SCHED) ? slice_val : '0;
    assign task_count  = COUNT_W'(run_cnt);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            idle_id_reg  <= '0;
            idle_pri_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IDLE_ID:  idle_id_reg  <= cfg_data;
                    CFG_IDLE_PRI: idle_pri_reg <= cfg_data[PRI_W-1:0];
                    default:      idle_id_reg  <= idle_id_reg;
                endcase
            end
        end
    end

    // Operand and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            cur_reg.id   <= task_id;
            cur_reg.rt   <= task_runtime;
            cur_reg.pri  <= task_priority;
            crun_reg     <= current_running;
            idle_rt_reg  <= idle_runtime;
            snow_reg     <= slice_now;
        end
        pick_reg   <= pick_next;
        cand_reg   <= cand_next;
        enq_reg    <= enq_next;
        sw_reg     <= sw_next;
        run_id_reg <= run_id_next;
        stat_reg   <= stat_next;
    end

`ifndef ASSERT_OFF
    // queue never holds more entries than cells
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(QUEUE_DEPTH))
        else $error("queue length beyond depth");

    // a result beat lasts one cycle and returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result beat not single cycle");

    // every result follows the insert step
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_INSERT))
        else $error("result without insert step");

    // length moves by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == $past(len_reg)) || (len_reg == $past(len_reg) + LEN_W'(1))
        || (len_reg + LEN_W'(1) == $past(len_reg)))
        else $error("queue length jumped");
`endif

endmodule : runtime_ordered_run_queue

`default_nettype wire
